// File: hdl/mad_pkg.sv
`timescale 1ns / 1ps

package mad_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register field widths
   localparam int DEADBAND_W = 12;
   localparam int SCALE_W    = 8;
   localparam int FREQ_W     = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_LIMIT = 2'd2;

   // Register reset values
   localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 12'd1;
   localparam logic [SCALE_W-1:0]    FREQ_SCALE_RST = 8'd25;
   localparam logic [FREQ_W-1:0]     FREQ_LIMIT_RST = 16'd1000;

endpackage

// File: hdl/mad_if.sv
`timescale 1ns / 1ps

// Sample channel
interface mad_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Result channel
interface mad_rsp_if #(parameter int SAMPLE_BITS = 12);
   logic                           valid;
   logic                           ready;
   logic [SAMPLE_BITS-1:0]         average;
   logic [SAMPLE_BITS-1:0]         held_value;
   logic [SAMPLE_BITS-1:0]         shown_distance;
   logic [mad_pkg::FREQ_W-1:0]     tone_freq;

   modport source (output valid, output average, output held_value,
                   output shown_distance, output tone_freq, input ready);
   modport sink   (input valid, input average, input held_value,
                   input shown_distance, input tone_freq, output ready);
endinterface

// File: hdl/mad_cell.sv
`timescale 1ns / 1ps

module mad_cell #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in_sel;

   // Take the neighbor's sample on a shift, hold otherwise
   assign data_in_sel = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in_sel;
      end
   end

   assign data_out = data_ff;

endmodule

// File: hdl/mad_window.sv
`timescale 1ns / 1ps

module mad_window #(
   parameter int WINDOW      = 20,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   out_valid,
   output logic [SAMPLE_BITS-1:0] out_sample,
   output logic [SAMPLE_BITS-1:0] out_average
);

   localparam int WIN_LOG = $clog2(WINDOW);
   localparam int SUM_W   = SAMPLE_BITS + WIN_LOG;
   localparam int SHIFT   = SUM_W + WIN_LOG;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic [SAMPLE_BITS-1:0] tap [WINDOW+1];
   logic                   shift_en;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic                   s2_valid_ff;
   logic [SAMPLE_BITS-1:0] s2_sample_ff;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [PROD_W-1:0]      recip_prod;

   assign shift_en = advance && in_valid;
   assign tap[0]   = in_sample;

   // Row of sample cells; the last tap is the sample leaving the window
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      mad_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  (tap[k]),
         .data_out (tap[k+1])
      );
   end

   // Drop the oldest sample, add the new one
   assign sum_in = sum_ff - SUM_W'(tap[WINDOW]) + SUM_W'(in_sample);
   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         if (in_valid) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         s1_sample_ff <= in_sample;
      end
   end

   // Divide by the window length through a reciprocal multiply
   assign recip_prod = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign avg_in     = recip_prod[SHIFT +: SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         avg_ff       <= avg_in;
         s2_sample_ff <= s1_sample_ff;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign out_sample  = s2_sample_ff;
   assign out_average = avg_ff;

endmodule

// File: hdl/moving_average_deadband_tone.sv
`timescale 1ns / 1ps

// Boxcar moving average of distance samples with a deadband hold and a
// tone-frequency map. Samples shift through a row of WINDOW cells that reset
// clears to zero, so the mean counts those zeros until the window has filled.
// A running sum is divided by WINDOW (truncated) through a reciprocal
// multiply. The block accepts one beat per clock cycle while no result beat
// is stalled and returns one result beat per sample; the four pipeline
// stages (sum, divide, deadband/multiply, clamp) advance together, so a
// stalled result beat holds the whole pipeline and req.ready follows it.
// Configuration: index 0 deadband, 1 freq_scale, 2 freq_limit; write only
// while no beat is in flight.
module moving_average_deadband_tone #(
   parameter int WINDOW      = 20,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   mad_req_if.sink                         req,
   mad_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [mad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mad_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DB_W    = mad_pkg::DEADBAND_W;
   localparam int CMP_W   = (SAMPLE_BITS > DB_W) ? SAMPLE_BITS : DB_W;
   localparam int MUL_W   = mad_pkg::SCALE_W + SAMPLE_BITS;
   localparam int CLAMP_W = (MUL_W > mad_pkg::FREQ_W) ? MUL_W : mad_pkg::FREQ_W;

   logic [DB_W-1:0]                deadband_ff;
   logic [mad_pkg::SCALE_W-1:0]    scale_ff;
   logic [mad_pkg::FREQ_W-1:0]     limit_ff;

   logic                           en;
   logic                           s2_valid;
   logic [SAMPLE_BITS-1:0]         s2_sample;
   logic [SAMPLE_BITS-1:0]         s2_avg;

   logic [SAMPLE_BITS-1:0]         held_ff, held_in;
   logic [SAMPLE_BITS-1:0]         diff;
   logic                           in_band;
   logic [SAMPLE_BITS-1:0]         shown_in;
   logic [MUL_W-1:0]               prod_in;

   logic                           s3_valid_ff;
   logic [SAMPLE_BITS-1:0]         s3_avg_ff;
   logic [SAMPLE_BITS-1:0]         s3_held_ff;
   logic [SAMPLE_BITS-1:0]         s3_shown_ff;
   logic [MUL_W-1:0]               s3_prod_ff;

   logic [mad_pkg::FREQ_W-1:0]     freq_in;
   logic                           rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]         rsp_avg_ff;
   logic [SAMPLE_BITS-1:0]         rsp_held_ff;
   logic [SAMPLE_BITS-1:0]         rsp_shown_ff;
   logic [mad_pkg::FREQ_W-1:0]     rsp_freq_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= mad_pkg::DEADBAND_RST;
         scale_ff    <= mad_pkg::FREQ_SCALE_RST;
         limit_ff    <= mad_pkg::FREQ_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            mad_pkg::CSR_DEADBAND:   deadband_ff <= csr_wdata[DB_W-1:0];
            mad_pkg::CSR_FREQ_SCALE: scale_ff    <= csr_wdata[mad_pkg::SCALE_W-1:0];
            mad_pkg::CSR_FREQ_LIMIT: limit_ff    <= csr_wdata[mad_pkg::FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless a result beat is stuck
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   mad_window #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .advance     (en),
      .in_valid    (req.valid),
      .in_sample   (req.sample),
      .out_valid   (s2_valid),
      .out_sample  (s2_sample),
      .out_average (s2_avg)
   );

   // Deadband: keep the held average for small changes
   assign diff     = (s2_avg >= held_ff) ? (s2_avg - held_ff) : (held_ff - s2_avg);
   assign in_band  = CMP_W'(diff) < CMP_W'(deadband_ff);
   assign held_in  = in_band ? held_ff : s2_avg;
   assign shown_in = in_band ? held_ff : s2_sample;
   assign prod_in  = MUL_W'(scale_ff) * MUL_W'(s2_avg);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid;
         if (s2_valid) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_avg_ff   <= s2_avg;
         s3_held_ff  <= held_in;
         s3_shown_ff <= shown_in;
         s3_prod_ff  <= prod_in;
      end
   end

   // Saturate the tone frequency at the limit
   assign freq_in = (CLAMP_W'(s3_prod_ff) > CLAMP_W'(limit_ff)) ?
                    limit_ff : s3_prod_ff[mad_pkg::FREQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_avg_ff   <= s3_avg_ff;
         rsp_held_ff  <= s3_held_ff;
         rsp_shown_ff <= s3_shown_ff;
         rsp_freq_ff  <= freq_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.average        = rsp_avg_ff;
   assign rsp.held_value     = rsp_held_ff;
   assign rsp.shown_distance = rsp_shown_ff;
   assign rsp.tone_freq      = rsp_freq_ff;

   // A held result beat stalls the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input accepted while result beat is stalled");

   // Either the hold applied or the held value took the average
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.shown_distance == rsp.held_value) ||
                     (rsp.held_value == rsp.average)))
      else $error("deadband outcome inconsistent");

   // No result beat in the cycle right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result beat right after reset");

endmodule
